@@ hdl/bfba_pkg.sv @@
// ----------------------------------------------------------------------------
// bfba_pkg
// Shared types and constants of the best-fit block allocator: payload
// structs, the search token that travels down the cell chain, and the
// control group broadcast to every cell.
// ----------------------------------------------------------------------------
package bfba_pkg;

   // table geometry
   localparam int BLOCKS    = 32;
   localparam int SIZE_BITS = 16;
   localparam int IDX_BITS  = $clog2(BLOCKS);
   localparam int CNT_BITS  = 6;
   // width wide enough to compare a cell index against the block count
   localparam int CMP_BITS  = (IDX_BITS + 1 > CNT_BITS) ? IDX_BITS + 1 : CNT_BITS;

   // request modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_ALLOC = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [4:0]  block_index;
      logic [15:0] size;
   } req_type;

   typedef struct packed {
      logic        granted;
      logic [4:0]  block_number;
      logic [15:0] leftover;
   } rsp_type;

   // best candidate so far, handed from cell to cell
   typedef struct packed {
      logic                 valid;
      logic                 found;
      logic [IDX_BITS-1:0]  best_idx;
      logic [SIZE_BITS-1:0] best_left;
   } token_type;

   // broadcast control for all cells
   typedef struct packed {
      logic                 load_en;
      logic                 claim_en;
      logic [IDX_BITS-1:0]  target_idx;
      logic [SIZE_BITS-1:0] load_size;
      logic [SIZE_BITS-1:0] req_size;
      logic [CNT_BITS-1:0]  block_count;
   } cell_ctl_type;

endpackage

@@ hdl/best_fit_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// best_fit_block_allocator_top
// Best-fit allocator over a chain of table cells. A request launches a
// search token that moves one cell per cycle; the last cell's token picks
// and claims the winning block.
// ----------------------------------------------------------------------------
// Load item: no result; busy stays low.
// Request: the result strobe follows the start transfer through the launch
//   register, the 32-cell chain (one cell per cycle) and the result register.
// A new request is taken only once the previous search has ended; one load per cycle while idle.
// Reset (synchronous, active high) clears used marks, block count and busy;
//   block sizes are undefined until loaded. The receiver cannot stall.
module best_fit_block_allocator_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  bfba_pkg::req_type    req_data,
   output logic                 rsp_valid,
   output bfba_pkg::rsp_type    rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [5:0]           csr_data
);
   import bfba_pkg::*;

   logic                   busy_ff;
   logic                   busy_in;
   logic                   launch_ff;
   logic                   launch_in;
   logic [SIZE_BITS-1:0]   req_size_ff;
   logic [SIZE_BITS-1:0]   req_size_in;
   logic [CNT_BITS-1:0]    block_count_ff;
   logic [CNT_BITS-1:0]    block_count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                rsp_data_ff;
   rsp_type                rsp_data_in;

   logic                   accept;
   cell_ctl_type           ctl;
   token_type              chain [0:BLOCKS];
   token_type              last_tok;
   logic [BLOCKS-1:0]      chain_valid;

   assign accept = start && !busy_ff;

   // configuration transfer, taken while no search is running
   assign csr_ready      = !busy_ff;
   assign block_count_in = (csr_valid && csr_ready) ? csr_data : block_count_ff;

   // request sequencing
   assign last_tok     = chain[BLOCKS];
   assign launch_in    = accept && (req_data.mode == MODE_ALLOC);
   assign req_size_in  = launch_in ? req_data.size : req_size_ff;
   assign busy_in      = launch_in ? 1'b1 : (last_tok.valid ? 1'b0 : busy_ff);
   assign rsp_valid_in = last_tok.valid;

   always_comb begin
      rsp_data_in = '0;
      if (last_tok.found) begin
         rsp_data_in.granted      = 1'b1;
         rsp_data_in.block_number = 5'(last_tok.best_idx);
         rsp_data_in.leftover     = 16'(last_tok.best_left);
      end
   end

   // broadcast control: loads only when idle, claims only at end of a search
   always_comb begin
      ctl             = '0;
      ctl.load_en     = accept && (req_data.mode == MODE_LOAD);
      ctl.claim_en    = last_tok.valid && last_tok.found;
      ctl.target_idx  = busy_ff ? last_tok.best_idx : IDX_BITS'(req_data.block_index);
      ctl.load_size   = SIZE_BITS'(req_data.size);
      ctl.req_size    = req_size_ff;
      ctl.block_count = block_count_ff;
   end

   always_ff @(posedge clock) begin
      req_size_ff <= req_size_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         busy_ff        <= 1'b0;
         launch_ff      <= 1'b0;
         block_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         busy_ff        <= busy_in;
         launch_ff      <= launch_in;
         block_count_ff <= block_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // fresh token enters the first cell: valid set, nothing found yet
   assign chain[0] = {launch_ff, {($bits(token_type) - 1){1'b0}}};

   // cell chain
   for (genvar i = 0; i < BLOCKS; i++) begin : g_cell
      bfba_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_BITS'(i)),
         .ctl        (ctl),
         .token_in   (chain[i]),
         .token_out  (chain[i+1])
      );
      assign chain_valid[i] = chain[i+1].valid;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // only one search token is ever in the chain
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0({launch_ff, chain_valid}))
      else $error("more than one search token in the chain");

   // a launched token always belongs to a running search
   a_launch_busy: assert property (@(posedge clock) disable iff (reset)
      launch_ff |-> busy_ff)
      else $error("token launched while not busy");

   // a result ends the search that produced it
   a_rsp_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(busy_ff) && !busy_ff))
      else $error("result strobe outside the end of a search");

   // a refused request carries zero index and leftover
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.granted) |->
         (rsp_data_ff.block_number == '0 && rsp_data_ff.leftover == '0))
      else $error("refused result with nonzero fields");
`endif

endmodule

@@ hdl/bfba_cell.sv @@
// ----------------------------------------------------------------------------
// bfba_cell
// One table entry: holds a block size and its used mark, and refines the
// passing search token with its own block before handing it on.
// ----------------------------------------------------------------------------
module bfba_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [bfba_pkg::IDX_BITS-1:0]    cell_index,
   input  bfba_pkg::cell_ctl_type           ctl,
   input  bfba_pkg::token_type              token_in,
   output bfba_pkg::token_type              token_out
);
   import bfba_pkg::*;

   logic [SIZE_BITS-1:0] size_ff;
   logic [SIZE_BITS-1:0] size_in;
   logic                 used_ff;
   logic                 used_in;
   token_type            token_ff;
   token_type            token_in_nxt;

   logic                 selected;
   logic                 active;
   logic                 fits;
   logic                 better;
   logic [SIZE_BITS-1:0] left;

   assign selected = (ctl.target_idx == cell_index);
   assign active   = (CMP_BITS'(cell_index) < CMP_BITS'(ctl.block_count));

   // size and mark updates: a load clears the mark, a claim sets it
   always_comb begin
      size_in = size_ff;
      used_in = used_ff;
      if (ctl.load_en && selected) begin
         size_in = ctl.load_size;
         used_in = 1'b0;
      end else if (ctl.claim_en && selected) begin
         used_in = 1'b1;
      end
   end

   // fit test against the token; strict compare keeps the lower index on ties
   assign left   = size_ff - ctl.req_size;
   assign fits   = active && !used_ff && (size_ff >= ctl.req_size);
   assign better = fits && (!token_in.found || (left < token_in.best_left));

   always_comb begin
      token_in_nxt = token_in;
      if (token_in.valid && better) begin
         token_in_nxt.found     = 1'b1;
         token_in_nxt.best_idx  = cell_index;
         token_in_nxt.best_left = left;
      end
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in;
      if (reset) begin
         used_ff  <= 1'b0;
         token_ff <= '0;
      end else begin
         used_ff  <= used_in;
         token_ff <= token_in_nxt;
      end
   end

   assign token_out = token_ff;

endmodule
